// ===== rtl/adx_pkg.sv =====
package adx_pkg;

	localparam int PRICE_BITS = 24;
	localparam int FRAC_BITS  = 16;

	localparam int ALPHA_W  = 16;
	localparam int THR_W    = 24;
	localparam int MAXPOS_W = 10;
	localparam int ADX_W    = 24;
	localparam int POS_W    = 11;
	localparam int BAL_W    = 48;
	localparam int ACT_W    = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// internal widths
	localparam int TRQ_W     = PRICE_BITS + FRAC_BITS;       // ATR, Q.F
	localparam int DI_W      = 2 * FRAC_BITS;                // DI, Q16.16
	localparam int MUL_A_W   = TRQ_W + 1;
	localparam int MUL_B_W   = PRICE_BITS;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;
	localparam int DIV_NUM_W = PRICE_BITS + 2 * FRAC_BITS;
	localparam int DIV_DEN_W = TRQ_W;
	localparam int HUND_W    = DI_W + 7;                     // mag * 100

	localparam logic [ALPHA_W-1:0]         ALPHA_RST     = 16'd8738;
	localparam logic signed [THR_W-1:0]    THRESHOLD_RST = 24'sd1638400;
	localparam logic [MAXPOS_W-1:0]        MAXPOS_RST    = 10'd5;

	localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
	localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE = 2'd0,
		ACT_BUY  = 2'd1,
		ACT_SELL = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA     = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_MAX_POS   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL_RUN,
		S_DIV_RUN,
		S_APPLY,
		S_DX,
		S_DECIDE,
		S_SQUARE
	} state_t;

	typedef enum logic [2:0] {
		PH_ATR,
		PH_DIP,
		PH_DIM,
		PH_ADX,
		PH_SQ
	} phase_t;

	// saturating balance add; addend magnitude stays far below 2^47
	function automatic logic signed [BAL_W-1:0] sat_bal(
		input logic signed [BAL_W-1:0] bal,
		input logic signed [BAL_W:0]   addend
	);
		logic signed [BAL_W:0] sum;
		sum = $signed({bal[BAL_W-1], bal}) + addend;
		if (sum[BAL_W] != sum[BAL_W-1]) begin
			sat_bal = sum[BAL_W] ? BAL_MIN : BAL_MAX;
		end else begin
			sat_bal = sum[BAL_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/adx_indicator_position_trader_unit.sv =====
// ADX position trader. One price bar in, one result out. The block keeps
// EMA-smoothed ATR, DI+, DI- and ADX, trades one unit at the close and squares
// off on the last bar. Products and quotients come from one bit-serial divider
// and one bit-serial multiplier. A later bar needs three divisions and up to
// five multiplications; a first-day bar needs only the square-off product,
// and that only when it is also a last bar. Only one bar is worked on at a
// time; the result register frees the input side while the previous result
// waits to be taken.
module adx_indicator_position_trader_unit (
	input  logic        clk,
	input  logic        arst_n,
	// bar_high, bar_low, bar_prev_close, bar_close (24 bits each, lowest first)
	input  logic [95:0] s_axis_tdata,
	input  logic        s_axis_tuser,   // first_day
	input  logic        s_axis_tlast,   // last_day
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// adx_value[23:0], trade_action[25:24], position_units[36:26],
	// cash_balance[84:37], zero pad
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [adx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adx_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int P  = adx_pkg::PRICE_BITS;
	localparam int F  = adx_pkg::FRAC_BITS;
	localparam int AW = adx_pkg::MUL_A_W;
	localparam int BW = adx_pkg::MUL_B_W;
	localparam int PW = adx_pkg::MUL_P_W;
	localparam int NW = adx_pkg::DIV_NUM_W;
	localparam int DW = adx_pkg::DIV_DEN_W;
	localparam int TW = adx_pkg::TRQ_W;
	localparam int IW = adx_pkg::DI_W;
	localparam int XW = adx_pkg::ADX_W;
	localparam int HW = adx_pkg::HUND_W;
	localparam int BLW = adx_pkg::BAL_W;
	localparam int QW = adx_pkg::POS_W;

	adx_pkg::state_t state_q, state_d;
	adx_pkg::phase_t phase_q, phase_d;

	// configuration
	logic [adx_pkg::ALPHA_W-1:0]        alpha_q;
	logic signed [adx_pkg::THR_W-1:0]   thr_q;
	logic [adx_pkg::MAXPOS_W-1:0]       maxpos_q;

	// bar being worked on
	logic [P-1:0] hi_q, lo_q, pc_q, cl_q;
	logic         first_q, last_q;
	logic [P-1:0] dmp_q, dmm_q;
	logic         neg_q;

	// indicator and account state
	logic [TW-1:0]          atr_q;
	logic [IW-1:0]          dip_q, dim_q;
	logic signed [XW-1:0]   adx_q;
	logic [P-1:0]           last_high_q, last_low_q;
	logic signed [QW-1:0]   held_q;
	logic signed [BLW-1:0]  bal_q;
	adx_pkg::action_t       action_q;

	logic signed [AW-1:0]   rnd_q;

	// result register
	logic                   out_valid_q;
	logic signed [XW-1:0]   out_adx_q;
	adx_pkg::action_t       out_action_q;
	logic signed [QW-1:0]   out_pos_q;
	logic signed [BLW-1:0]  out_bal_q;

	// arithmetic units
	logic                   mul_start, mul_done;
	logic signed [AW-1:0]   mul_a;
	logic [BW-1:0]          mul_b;
	logic signed [PW-1:0]   mul_prod;
	logic                   div_start, div_done;
	logic [NW-1:0]          div_num, div_quot;
	logic [DW-1:0]          div_den;

	logic in_fire;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == adx_pkg::S_IDLE);
	assign cfg_ready     = 1'b1;

	// true range and directional moves
	logic signed [P:0] ra, rb, rc, tr_ab, tr_max;
	logic [P-1:0]      tr_val;
	logic [TW-1:0]     tr_q;
	logic [P-1:0]      dmp_w, dmm_w;

	always_comb begin
		ra     = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
		rb     = $signed({1'b0, hi_q}) - $signed({1'b0, pc_q});
		rc     = $signed({1'b0, lo_q}) - $signed({1'b0, pc_q});
		tr_ab  = (ra > rb) ? ra : rb;
		tr_max = (rc > tr_ab) ? rc : tr_ab;
		tr_val = tr_max[P] ? '0 : tr_max[P-1:0];
		tr_q   = {tr_val, {F{1'b0}}};
		dmp_w  = (hi_q > last_high_q) ? hi_q - last_high_q : '0;
		dmm_w  = (lo_q > last_low_q) ? lo_q - last_low_q : '0;
	end

	// EMA terms
	logic signed [TW:0]    atr_diff;
	logic [IW-1:0]         di_x;
	logic signed [IW:0]    dip_diff, dim_diff;
	logic signed [XW-1:0]  dx;
	logic signed [XW:0]    adx_diff;
	logic signed [PW-1:0]  rounded;
	logic [TW-1:0]         atr_new;
	logic [IW:0]           di_sum;
	logic signed [IW:0]    di_diff;
	logic [IW-1:0]         di_mag;
	logic [HW-1:0]         di_mag100;

	always_comb begin
		atr_diff  = $signed({1'b0, tr_q}) - $signed({1'b0, atr_q});
		di_x      = (div_quot[NW-1:IW] != '0) ? {IW{1'b1}} : div_quot[IW-1:0];
		dip_diff  = $signed({1'b0, di_x}) - $signed({1'b0, dip_q});
		dim_diff  = $signed({1'b0, di_x}) - $signed({1'b0, dim_q});
		dx        = neg_q ? -$signed(div_quot[XW-1:0]) : $signed(div_quot[XW-1:0]);
		adx_diff  = $signed({dx[XW-1], dx}) - $signed({adx_q[XW-1], adx_q});
		// round half up, then drop the fraction
		rounded   = mul_prod + PW'(1 << (F - 1));
		atr_new   = atr_q + rnd_q[TW-1:0];
		di_sum    = {1'b0, dip_q} + {1'b0, dim_q};
		di_diff   = $signed({1'b0, dip_q}) - $signed({1'b0, dim_q});
		di_mag    = di_diff[IW] ? IW'(-di_diff) : di_diff[IW-1:0];
		di_mag100 = {di_mag, 6'b0} + {1'b0, di_mag, 5'b0} + {5'b0, di_mag, 2'b0};
	end

	logic signed [QW-1:0] maxpos_s;
	logic                 buy, sell;
	logic signed [BLW:0]  cl_add;

	always_comb begin
		maxpos_s = $signed({1'b0, maxpos_q});
		buy      = (adx_q > thr_q) && (held_q < maxpos_s);
		sell     = (adx_q < thr_q) && (held_q > -maxpos_s);
		cl_add   = $signed({{(BLW+1-P){1'b0}}, cl_q});
	end

	adx_serial_mul #(.A_W(AW), .B_W(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	adx_serial_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adx_pkg::S_IDLE;
			phase_q <= adx_pkg::PH_ATR;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		mul_start = 1'b0;
		mul_a     = AW'(atr_diff);
		mul_b     = BW'(alpha_q);
		div_start = 1'b0;
		div_num   = {dmp_q, {IW{1'b0}}};
		div_den   = atr_new;
		unique case (state_q)
			adx_pkg::S_IDLE: begin
				if (in_fire) begin
					state_d = adx_pkg::S_PREP;
				end
			end
			adx_pkg::S_PREP: begin
				if (first_q) begin
					state_d = adx_pkg::S_SQUARE;
				end else begin
					mul_start = 1'b1;
					phase_d   = adx_pkg::PH_ATR;
					state_d   = adx_pkg::S_MUL_RUN;
				end
			end
			adx_pkg::S_MUL_RUN: begin
				if (mul_done) begin
					state_d = adx_pkg::S_APPLY;
				end
			end
			adx_pkg::S_APPLY: begin
				unique case (phase_q)
					adx_pkg::PH_ATR: begin
						if (atr_new == '0) begin
							state_d = adx_pkg::S_SQUARE;
						end else begin
							div_start = 1'b1;
							phase_d   = adx_pkg::PH_DIP;
							state_d   = adx_pkg::S_DIV_RUN;
						end
					end
					adx_pkg::PH_DIP: begin
						div_start = 1'b1;
						div_num   = {dmm_q, {IW{1'b0}}};
						div_den   = atr_q;
						phase_d   = adx_pkg::PH_DIM;
						state_d   = adx_pkg::S_DIV_RUN;
					end
					adx_pkg::PH_DIM: state_d = adx_pkg::S_DX;
					adx_pkg::PH_ADX: state_d = adx_pkg::S_DECIDE;
					default:         state_d = adx_pkg::S_IDLE;  // square-off done
				endcase
				if (phase_q == adx_pkg::PH_SQ || phase_q == adx_pkg::PH_ADX) begin
					if (phase_q == adx_pkg::PH_SQ) begin
						state_d = (out_valid_q && !m_axis_tready) ? adx_pkg::S_APPLY
						                                           : adx_pkg::S_IDLE;
					end
				end
			end
			adx_pkg::S_DX: begin
				if (di_sum == '0) begin
					state_d = adx_pkg::S_SQUARE;
				end else begin
					div_start = 1'b1;
					div_num   = NW'({di_mag100, {F{1'b0}}});
					div_den   = DW'(di_sum);
					phase_d   = adx_pkg::PH_ADX;
					state_d   = adx_pkg::S_DIV_RUN;
				end
			end
			adx_pkg::S_DIV_RUN: begin
				if (div_done) begin
					mul_start = 1'b1;
					state_d   = adx_pkg::S_MUL_RUN;
					case (phase_q)
						adx_pkg::PH_DIP: mul_a = AW'(dip_diff);
						adx_pkg::PH_DIM: mul_a = AW'(dim_diff);
						default:         mul_a = AW'(adx_diff);
					endcase
				end
			end
			adx_pkg::S_DECIDE: state_d = adx_pkg::S_SQUARE;
			adx_pkg::S_SQUARE: begin
				if (last_q) begin
					mul_start = 1'b1;
					mul_a     = AW'(held_q);
					mul_b     = BW'(cl_q);
					phase_d   = adx_pkg::PH_SQ;
					state_d   = adx_pkg::S_MUL_RUN;
				end else begin
					phase_d = adx_pkg::PH_SQ;
					state_d = adx_pkg::S_APPLY;
				end
			end
			default: state_d = adx_pkg::S_IDLE;
		endcase
	end

	// result is loaded when the square-off step ends and the register is free
	logic out_load;
	assign out_load = (state_q == adx_pkg::S_APPLY) && (phase_q == adx_pkg::PH_SQ)
	                  && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= adx_pkg::ALPHA_RST;
			thr_q       <= adx_pkg::THRESHOLD_RST;
			maxpos_q    <= adx_pkg::MAXPOS_RST;
			atr_q       <= '0;
			dip_q       <= '0;
			dim_q       <= '0;
			adx_q       <= '0;
			last_high_q <= '0;
			last_low_q  <= '0;
			held_q      <= '0;
			bal_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					adx_pkg::REG_ALPHA:     alpha_q  <= cfg_data[adx_pkg::ALPHA_W-1:0];
					adx_pkg::REG_THRESHOLD: thr_q    <= $signed(cfg_data[adx_pkg::THR_W-1:0]);
					adx_pkg::REG_MAX_POS:   maxpos_q <= cfg_data[adx_pkg::MAXPOS_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				adx_pkg::S_PREP: begin
					last_high_q <= hi_q;
					last_low_q  <= lo_q;
					if (first_q) begin
						atr_q <= tr_q;
						dip_q <= '0;
						dim_q <= '0;
					end
				end
				adx_pkg::S_APPLY: begin
					case (phase_q)
						adx_pkg::PH_ATR: begin
							atr_q <= atr_new;
							if (atr_new == '0) begin
								adx_q <= '0;
							end
						end
						adx_pkg::PH_DIP: dip_q <= dip_q + rnd_q[IW-1:0];
						adx_pkg::PH_DIM: dim_q <= dim_q + rnd_q[IW-1:0];
						adx_pkg::PH_ADX: adx_q <= adx_q + rnd_q[XW-1:0];
						default: ;
					endcase
				end
				adx_pkg::S_DX: begin
					if (di_sum == '0) begin
						adx_q <= '0;
					end
				end
				adx_pkg::S_DECIDE: begin
					if (buy) begin
						held_q <= held_q + QW'(1);
						bal_q  <= adx_pkg::sat_bal(bal_q, -cl_add);
					end else if (sell) begin
						held_q <= held_q - QW'(1);
						bal_q  <= adx_pkg::sat_bal(bal_q, cl_add);
					end
				end
				default: ;
			endcase
			// square-off on a last bar, applied once when the product is ready
			if (state_q == adx_pkg::S_MUL_RUN && phase_q == adx_pkg::PH_SQ && mul_done) begin
				bal_q  <= adx_pkg::sat_bal(bal_q, mul_prod[BLW:0]);
				held_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hi_q     <= s_axis_tdata[P-1:0];
			lo_q     <= s_axis_tdata[2*P-1:P];
			pc_q     <= s_axis_tdata[3*P-1:2*P];
			cl_q     <= s_axis_tdata[4*P-1:3*P];
			first_q  <= s_axis_tuser;
			last_q   <= s_axis_tlast;
			action_q <= adx_pkg::ACT_NONE;
		end
		if (state_q == adx_pkg::S_PREP) begin
			dmp_q <= dmp_w;
			dmm_q <= dmm_w;
		end
		if (state_q == adx_pkg::S_DX) begin
			neg_q <= di_diff[IW];
		end
		if (state_q == adx_pkg::S_DECIDE) begin
			if (buy) begin
				action_q <= adx_pkg::ACT_BUY;
			end else if (sell) begin
				action_q <= adx_pkg::ACT_SELL;
			end
		end
		if (mul_done) begin
			rnd_q <= rounded[F+AW-1:F];
		end
		if (out_load) begin
			out_adx_q    <= adx_q;
			out_action_q <= action_q;
			out_pos_q    <= held_q;
			out_bal_q    <= bal_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_bal_q, out_pos_q, out_action_q, out_adx_q};

endmodule

// ===== rtl/adx_serial_div.sv =====
module adx_serial_div #(
	parameter int NUM_W = adx_pkg::DIV_NUM_W,
	parameter int DEN_W = adx_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_sub;
	logic           ge;

	// restoring division, one quotient bit per cycle
	assign trial     = {rem_q, quo_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/adx_serial_mul.sv =====
module adx_serial_mul #(
	parameter int A_W = adx_pkg::MUL_A_W,
	parameter int B_W = adx_pkg::MUL_B_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [A_W-1:0]      a,
	input  logic [B_W-1:0]             b,
	output logic                       done,
	output logic signed [A_W+B_W:0]    prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic                   run_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [A_W-1:0]  a_q;
	logic [B_W-1:0]         b_q;
	logic signed [A_W:0]    hi_q;
	logic [B_W-1:0]         lo_q;

	logic signed [A_W:0] psum;

	// shift-add, multiplier bits taken LSB first, partial product shifts right
	assign psum = hi_q + (b_q[0] ? (A_W+1)'(a_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (run_q) begin
			b_q  <= {1'b0, b_q[B_W-1:1]};
			hi_q <= {psum[A_W], psum[A_W:1]};
			lo_q <= {psum[0], lo_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// ===== rtl/adx_checker.sv =====
module adx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata
);

	// a held result does not change under backpressure
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one bar at a time: input closes right after an item is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a bar is in work");

	// trade code is none, buy or sell
	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[25:24] != 2'b11)
		else $error("bad trade code");

	// position never reaches the most negative code
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[36:26] != 11'h400)
		else $error("position out of range");

endmodule

bind adx_indicator_position_trader_unit adx_checker u_adx_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic [23:0] hi;
		logic [23:0] lo;
		logic [23:0] pc;
		logic [23:0] cl;
		logic        first;
		logic        last;
		logic        typed;     // expected values below are given literally
		logic [23:0] adx;
		adx_pkg::action_t act;
		logic [10:0] pos;
		logic [47:0] bal;
	} bar_row_t;

	typedef struct {
		logic [23:0] adx;
		adx_pkg::action_t act;
		logic [10:0] pos;
		logic [47:0] bal;
	} day_result_t;

	localparam longint BAL_HI = (64'sd1 <<< 47) - 1;
	localparam longint BAL_LO = -(64'sd1 <<< 47);

	logic        clk;
	logic        arst_n;
	logic [95:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [adx_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [adx_pkg::CFG_DATA_W-1:0] cfg_data;

	adx_indicator_position_trader_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// trader state mirrored by the predictor
	logic [15:0] ema_alpha;
	longint      trade_thr;
	int          pos_limit;
	longint      atr_q, dip_q, dim_q, adx_q, prev_hi, prev_lo, bal_c;
	int          units;

	day_result_t pending_days[$];
	int          mismatches;
	int          days_sent;
	int          days_checked;
	int          buys_seen;
	int          sells_seen;
	int          send_idle_pct;
	int          recv_stall_pct;

	function automatic longint ema_step(longint old_v, longint x);
		return old_v + ((((x - old_v) * longint'(ema_alpha)) + 64'sd32768) >>> 16);
	endfunction

	function automatic longint di_ratio(longint dm, longint atr);
		longint r;
		r = (dm <<< 32) / atr;
		return (r > 64'sh0FFFFFFFF) ? 64'sh0FFFFFFFF : r;
	endfunction

	function automatic longint bal_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > BAL_HI) return BAL_HI;
		if (s < BAL_LO) return BAL_LO;
		return s;
	endfunction

	function automatic day_result_t trade_day(bar_row_t b);
		longint ra, rb, rc, tr, dmp, dmm, sum, diff, mag, dx, cl;
		day_result_t r;
		r.act = adx_pkg::ACT_NONE;
		cl = longint'(b.cl);
		ra = longint'(b.hi) - longint'(b.lo);
		rb = longint'(b.hi) - longint'(b.pc);
		rc = longint'(b.lo) - longint'(b.pc);
		tr = (ra > rb) ? ra : rb;
		if (rc > tr) tr = rc;
		if (tr < 0) tr = 0;
		if (b.first) begin
			atr_q = tr <<< 16;
			dip_q = 0;
			dim_q = 0;
		end else begin
			dmp = (longint'(b.hi) > prev_hi) ? longint'(b.hi) - prev_hi : 0;
			dmm = (longint'(b.lo) > prev_lo) ? longint'(b.lo) - prev_lo : 0;
			atr_q = ema_step(atr_q, tr <<< 16);
			if (atr_q == 0) begin
				adx_q = 0;
			end else begin
				dip_q = ema_step(dip_q, di_ratio(dmp, atr_q));
				dim_q = ema_step(dim_q, di_ratio(dmm, atr_q));
				sum = dip_q + dim_q;
				if (sum == 0) begin
					adx_q = 0;
				end else begin
					diff = dip_q - dim_q;
					mag = (diff < 0) ? -diff : diff;
					dx = ((mag * 100) <<< 16) / sum;
					if (diff < 0) dx = -dx;
					adx_q = ema_step(adx_q, dx);
					if (adx_q > trade_thr && units < pos_limit) begin
						units++;
						bal_c = bal_add(bal_c, -cl);
						r.act = adx_pkg::ACT_BUY;
					end else if (adx_q < trade_thr && units > -pos_limit) begin
						units--;
						bal_c = bal_add(bal_c, cl);
						r.act = adx_pkg::ACT_SELL;
					end
				end
			end
		end
		prev_hi = longint'(b.hi);
		prev_lo = longint'(b.lo);
		if (b.last) begin
			bal_c = bal_add(bal_c, longint'(units) * cl);
			units = 0;
		end
		r.adx = adx_q[23:0];
		r.pos = units[10:0];
		r.bal = bal_c[47:0];
		return r;
	endfunction

	task automatic send_bar(bar_row_t b);
		day_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata  <= {b.cl, b.pc, b.lo, b.hi};
		s_axis_tuser  <= b.first;
		s_axis_tlast  <= b.last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		r = trade_day(b);
		if (b.typed) begin
			r.adx = b.adx;
			r.act = b.act;
			r.pos = b.pos;
			r.bal = b.bal;
		end
		pending_days.push_back(r);
		days_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_days.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// valid stays high; the caller drops it after the last write
	task automatic write_reg(adx_pkg::cfg_reg_t idx, logic [23:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			adx_pkg::REG_ALPHA:     ema_alpha = val[15:0];
			adx_pkg::REG_THRESHOLD: trade_thr = longint'($signed(val));
			adx_pkg::REG_MAX_POS:   pos_limit = int'(val[9:0]);
			default: ;
		endcase
	endtask

	function automatic logic [23:0] clamp_px(longint v);
		if (v < 0) return 24'd0;
		if (v > 64'sd16777215) return 24'hFFFFFF;
		return v[23:0];
	endfunction

	function automatic bar_row_t plain_bar(logic [23:0] hi, logic [23:0] lo,
		logic [23:0] pc, logic [23:0] cl, logic first, logic last);
		bar_row_t b;
		b = '{hi, lo, pc, cl, first, last, 1'b0, 24'd0, adx_pkg::ACT_NONE, 11'd0, 48'd0};
		return b;
	endfunction

	// one trading run: drifting prices, mostly opened by a first day and closed by a last day; or a noise item
	task automatic send_random_run();
		longint px, drift, o, c, h, l;
		int     len;
		bar_row_t b;
		if ($urandom_range(9) == 0) begin
			b = plain_bar(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			send_bar(b);
			return;
		end
		len = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 15);
		px = ($urandom_range(7) == 0) ? longint'($urandom_range(16777215))
			: longint'($urandom_range(200000, 10000));
		drift = longint'($urandom_range(400)) - 200;
		for (int i = 0; i < len; i++) begin
			o = px;
			c = px + drift + longint'($urandom_range(600)) - 300;
			h = ((o > c) ? o : c) + longint'($urandom_range(200));
			l = ((o < c) ? o : c) - longint'($urandom_range(200));
			if ($urandom_range(19) == 0) begin
				h = l - longint'($urandom_range(50));   // inverted bar
			end
			b = plain_bar(clamp_px(h), clamp_px(l), clamp_px(o), clamp_px(c),
				(i == 0) && ($urandom_range(15) != 0),
				(i == len - 1) && ($urandom_range(7) != 0));
			send_bar(b);
			px = longint'(clamp_px(c));
		end
	endtask

	bar_row_t opening_bars[$];

	initial begin
		// all-zero first day right after reset: state stays as after reset
		opening_bars.push_back('{24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b0,
			1'b1, 24'd0, adx_pkg::ACT_NONE, 11'd0, 48'd0});
		// later bar against reset state, then a fresh first day
		opening_bars.push_back(plain_bar(24'd5000, 24'd4000, 24'd4500, 24'd4800, 1'b0, 1'b0));
		opening_bars.push_back(plain_bar(24'd1000, 24'd1000, 24'd1000, 24'd1000, 1'b1, 1'b0));
		// flat bar: zero ATR
		opening_bars.push_back(plain_bar(24'd1000, 24'd1000, 24'd1000, 24'd1000, 1'b0, 1'b0));
		opening_bars.push_back(plain_bar(24'd2000, 24'd1500, 24'd1800, 24'd1900, 1'b1, 1'b0));
		// no directional move: zero DI sum
		opening_bars.push_back(plain_bar(24'd1900, 24'd1400, 24'd1700, 24'd1600, 1'b0, 1'b0));
		for (int i = 0; i < 6; i++)
			opening_bars.push_back(plain_bar(24'd2000 + 24'(i * 400), 24'd1600 + 24'(i * 400),
				24'd1800 + 24'(i * 400), 24'd1950 + 24'(i * 400), 1'b0, 1'b0));
		for (int i = 0; i < 5; i++)
			opening_bars.push_back(plain_bar(24'd4000 - 24'(i * 500), 24'd3500 - 24'(i * 500),
				24'd3800 - 24'(i * 500), 24'd3600 - 24'(i * 500), 1'b0, 1'b0));
		// inverted bar and price extremes
		opening_bars.push_back(plain_bar(24'd100, 24'd900, 24'd500, 24'd300, 1'b0, 1'b0));
		opening_bars.push_back(plain_bar(24'hFFFFFF, 24'd0, 24'd0, 24'hFFFFFF, 1'b0, 1'b0));
		opening_bars.push_back(plain_bar(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 1'b0, 1'b0));
		opening_bars.push_back(plain_bar(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 1'b0, 1'b1));
		// first and last on one bar
		opening_bars.push_back(plain_bar(24'd3000, 24'd2000, 24'd2500, 24'd2800, 1'b1, 1'b1));
	end

	always @(posedge clk) begin
		day_result_t want;
		logic [23:0] got_adx;
		logic [1:0]  got_act;
		logic [10:0] got_pos;
		logic [47:0] got_bal;
		if (m_axis_tvalid && m_axis_tready) begin
			got_adx = m_axis_tdata[23:0];
			got_act = m_axis_tdata[25:24];
			got_pos = m_axis_tdata[36:26];
			got_bal = m_axis_tdata[84:37];
			if (got_act == adx_pkg::ACT_BUY) buys_seen++;
			if (got_act == adx_pkg::ACT_SELL) sells_seen++;
			if (pending_days.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: adx %0d act %0d pos %0d bal %0d",
						$signed(got_adx), got_act, $signed(got_pos), $signed(got_bal));
			end else begin
				want = pending_days.pop_front();
				days_checked++;
				if (got_adx !== want.adx || got_act !== want.act ||
					got_pos !== want.pos || got_bal !== want.bal) begin
					mismatches++;
					if (mismatches <= 10)
						$display("day %0d: adx %0d/%0d act %0d/%0d pos %0d/%0d bal %0d/%0d",
							days_checked, $signed(got_adx), $signed(want.adx), got_act,
							want.act, $signed(got_pos), $signed(want.pos),
							$signed(got_bal), $signed(want.bal));
				end
			end
		end
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#20_000_000;
		$display("timeout waiting for results");
		$display("[adx_indicator_position_trader_unit] ERROR");
		$finish;
	end

	initial begin
		logic [23:0] phase_cfg[5][3];
		arst_n        = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		s_axis_tvalid = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = adx_pkg::REG_ALPHA;
		cfg_data      = '0;
		mismatches = 0;
		days_sent = 0;
		days_checked = 0;
		buys_seen = 0;
		sells_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		ema_alpha = adx_pkg::ALPHA_RST;
		trade_thr = longint'(adx_pkg::THRESHOLD_RST);
		pos_limit = int'(adx_pkg::MAXPOS_RST);
		atr_q = 0; dip_q = 0; dim_q = 0; adx_q = 0;
		prev_hi = 0; prev_lo = 0; bal_c = 0; units = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bars[i]) send_bar(opening_bars[i]);
		drain_results();

		phase_cfg[0] = '{24'd8738, 24'd1638400, 24'd5};
		phase_cfg[1] = '{24'd65535, 24'h9C0000, 24'd0};          // -100.0
		phase_cfg[2] = '{24'd1, 24'd6553600, 24'd1023};
		phase_cfg[3] = '{24'd20000, 24'd0, 24'd3};
		phase_cfg[4] = '{24'($urandom_range(65535, 1)),
			24'(int'($urandom_range(3276800)) - 1638400), 24'($urandom_range(12))};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(adx_pkg::REG_ALPHA, phase_cfg[ph][0]);
			write_reg(adx_pkg::REG_THRESHOLD, phase_cfg[ph][1]);
			write_reg(adx_pkg::REG_MAX_POS, phase_cfg[ph][2]);
			cfg_valid <= 1'b0;
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			while (days_sent < opening_bars.size() + (ph + 1) * 240) send_random_run();
			drain_results();
		end

		$display("%0d bars over 5 register settings and 4 idle mixes, %0d buys, %0d sells",
			days_checked, buys_seen, sells_seen);
		if (mismatches == 0) begin
			$display("[adx_indicator_position_trader_unit] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[adx_indicator_position_trader_unit] ERROR");
		end
		$finish;
	end

endmodule
